FILE: rtl/core/sitda_pkg.sv
`default_nettype none

package sitda_pkg;

  // Width of the input integer field and of the character code field.
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned CHAR_W = 6;

  // Binary bits folded into the decimal register per conversion cycle.
  localparam int unsigned BITS_PER_STEP = 4;

  // Depth of the queue between the front end and the conversion engine.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_CONV,
    BS_FIND,
    BS_SIGN,
    BS_DIGIT
  } back_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/signed_int_to_decimal_ascii_unit.sv
// Converts one signed integer per transaction into its decimal text, one ASCII character
// per result, most significant first, with a leading minus sign for negative values, no
// leading zeros and no terminator; the final character of each number carries last_char_o.
// A transaction is taken on a rising edge with start_i high and busy_o low. Each character
// is shown for exactly one cycle with char_valid_o high, and the receiver cannot stall it,
// so it must take every character as it appears. A two-entry queue sits between the input
// side and the conversion engine, so up to two numbers can be taken while one is still
// being printed; busy_o is high only while that queue is full. The engine takes a number
// from the queue, converts its magnitude to decimal in the shared four-bit-per-cycle
// conversion loop, locates the leading digit and then emits the characters in turn on
// the single output port. Nothing is carried from one number to the next.

`default_nettype none

module signed_int_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [sitda_pkg::NUM_W-1:0]  number_in_i,
  output logic                                char_valid_o,
  output logic        [sitda_pkg::CHAR_W-1:0] char_code_o,
  output logic                                last_char_o
);
  import sitda_pkg::*;

  // The magnitude is padded to whole four-bit steps of the conversion loop.
  localparam int unsigned MAG_W = ((VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP)
                                  * BITS_PER_STEP;
  // Enough decimal digits to hold any MAG_W-bit value.
  localparam int unsigned NDIG  = (MAG_W * 3) / 10 + 1;

  logic             front_neg;
  logic [MAG_W-1:0] front_mag;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [MAG_W:0]   q_data;

  // The front end takes the sign and forms the unsigned magnitude in the accepting cycle.
  sitda_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAG_W      (MAG_W)
  ) u_front (
    .number_in_i (number_in_i),
    .neg_o       (front_neg),
    .mag_o       (front_mag)
  );

  assign push   = start_i && !q_full;
  assign busy_o = q_full;

  sitda_fifo #(
    .WIDTH (MAG_W + 1)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({front_neg, front_mag}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // The back end converts to decimal and streams the characters out.
  sitda_back #(
    .MAG_W (MAG_W),
    .NDIG  (NDIG)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_valid),
    .entry_i       (q_data),
    .pop_o         (q_pop),
    .char_valid_o  (char_valid_o),
    .char_code_o   (char_code_o),
    .last_char_o   (last_char_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/sitda_front.sv
`default_nettype none

module sitda_front #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned MAG_W      = 32
) (
  input  logic signed [sitda_pkg::NUM_W-1:0] number_in_i,
  output logic                               neg_o,
  output logic        [MAG_W-1:0]            mag_o
);
  import sitda_pkg::*;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_vb;

  // Only the low VALUE_BITS bits take part; a wider setting sees the field zero-extended.
  assign raw    = VALUE_BITS'($unsigned(number_in_i));
  assign neg_o  = raw[VALUE_BITS-1];
  // The negation is taken as unsigned, so the most negative value keeps its full magnitude.
  assign mag_vb = neg_o ? (~raw + 1'b1) : raw;
  assign mag_o  = MAG_W'(mag_vb);

endmodule

`default_nettype wire

FILE: rtl/core/sitda_fifo.sv
`default_nettype none

module sitda_fifo #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);
  import sitda_pkg::*;

  logic [WIDTH-1:0]  mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sitda_back.sv
`default_nettype none

module sitda_back #(
  parameter int unsigned MAG_W = 32,
  parameter int unsigned NDIG  = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         entry_valid_i,
  input  logic [MAG_W:0]               entry_i,
  output logic                         pop_o,
  output logic                         char_valid_o,
  output logic [sitda_pkg::CHAR_W-1:0] char_code_o,
  output logic                         last_char_o
);
  import sitda_pkg::*;

  localparam int unsigned STEPS  = MAG_W / BITS_PER_STEP;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam int unsigned IDX_W  = $clog2(NDIG);
  localparam int unsigned BCD_W  = NDIG * 4;
  localparam int unsigned DD_W   = BCD_W + MAG_W;

  back_state_e        state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               neg_q, neg_d;
  logic [MAG_W-1:0]   bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [DD_W-1:0]    dd_next;
  logic [IDX_W-1:0]   lead;
  logic [3:0]         digit;

  // Shift-and-add-three, four binary bits per cycle; each pass adjusts all digits at once.
  always_comb begin
    logic [DD_W-1:0] acc;
    logic [3:0]      nib;
    acc = {bcd_q, bin_q};
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int j = 0; j < NDIG; j++) begin
        nib = acc[MAG_W + 4*j +: 4];
        if (nib >= 4'd5) begin
          nib = nib + 4'd3;
        end
        acc[MAG_W + 4*j +: 4] = nib;
      end
      acc = acc << 1;
    end
    dd_next = acc;
  end

  // Position of the most significant non-zero digit; zero leaves a single digit.
  always_comb begin
    lead = '0;
    for (int j = 0; j < NDIG; j++) begin
      if (bcd_q[4*j +: 4] != 4'd0) begin
        lead = IDX_W'(j);
      end
    end
  end

  assign digit = bcd_q[{idx_q, 2'b00} +: 4];

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    neg_d   = neg_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    case (state_q)
      BS_IDLE: begin
        if (entry_valid_i) begin
          neg_d   = entry_i[MAG_W];
          bin_d   = entry_i[MAG_W-1:0];
          bcd_d   = '0;
          step_d  = '0;
          state_d = BS_CONV;
        end
      end
      BS_CONV: begin
        {bcd_d, bin_d} = dd_next;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(STEPS - 1)) begin
          state_d = BS_FIND;
        end
      end
      BS_FIND: begin
        idx_d   = lead;
        state_d = neg_q ? BS_SIGN : BS_DIGIT;
      end
      BS_SIGN: begin
        state_d = BS_DIGIT;
      end
      BS_DIGIT: begin
        if (idx_q == '0) begin
          state_d = BS_IDLE;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    char_valid_o = 1'b0;
    char_code_o  = ASCII_ZERO;
    last_char_o  = 1'b0;
    case (state_q)
      BS_IDLE: begin
        pop_o = entry_valid_i;
      end
      BS_SIGN: begin
        char_valid_o = 1'b1;
        char_code_o  = ASCII_MINUS;
      end
      BS_DIGIT: begin
        char_valid_o = 1'b1;
        char_code_o  = ASCII_ZERO + {2'b00, digit};
        last_char_o  = (idx_q == '0);
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

`default_nettype wire
